// ----- rtl/tstr_pkg.sv -----
// ----------------------------------------------------------------------------
// tstr_pkg
// Shared constants, tint tables, tile codes and types for the tinted sprite
// renderer.
// ----------------------------------------------------------------------------
package tstr_pkg;

  localparam int TILE_SIZE_DEFAULT           = 14;
  localparam int ATLAS_TILES_PER_ROW_DEFAULT = 5;

  // queue depths between the parts
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  // tint index field in cell and goal codes
  localparam int          TINT_LSB  = 9;
  localparam logic [15:0] TINT_MASK = 16'(7 << TINT_LSB);

  // tile codes, color bits cleared
  localparam logic [15:0] TC_EMPTY     = 16'd0;
  localparam logic [15:0] TC_R1C0      = 16'd9;
  localparam logic [15:0] TC_R1C1      = 16'd1;
  localparam logic [15:0] TC_R1C2      = 16'd53;
  localparam logic [15:0] TC_R1C3      = 16'd32789;
  localparam logic [15:0] TC_R1C4      = 16'd17;
  localparam logic [15:0] TC_R2C0      = 16'd32884;
  localparam logic [15:0] TC_R2C1      = 16'd48;
  localparam logic [15:0] TC_R2C2      = 16'd16;
  localparam logic [15:0] TC_R2C3      = 16'd32788;
  localparam logic [15:0] TC_R2C4      = 16'd85;
  localparam logic [15:0] TC_R3C0      = 16'd152;
  localparam logic [15:0] TC_R3C1      = 16'd272;
  localparam logic [15:0] TC_R3C2      = 16'd144;

  // blend arithmetic: pixel = floor(num / 2550), num < 2^20
  localparam int NUM_W       = 20;
  localparam int BLEND_DIV   = 2550;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / BLEND_DIV;
  localparam int RECIP_W     = 13;

  // tints in tenths, per index and channel (R, G, B)
  typedef logic [3:0] tenth_t;

  localparam tenth_t FG_TENTHS [8][3] = '{
    '{4'd4,  4'd4,  4'd4},  '{4'd8, 4'd2, 4'd2}, '{4'd2, 4'd8, 4'd2},
    '{4'd8,  4'd8,  4'd2},  '{4'd2, 4'd2, 4'd8}, '{4'd8, 4'd2, 4'd8},
    '{4'd2,  4'd8,  4'd8},  '{4'd10, 4'd10, 4'd10}
  };

  localparam tenth_t BG_TENTHS [8][3] = '{
    '{4'd6, 4'd6, 4'd6}, '{4'd9, 4'd6, 4'd6}, '{4'd6, 4'd9, 4'd6},
    '{4'd9, 4'd9, 4'd6}, '{4'd5, 4'd5, 4'd9}, '{4'd9, 4'd6, 4'd9},
    '{4'd6, 4'd9, 4'd9}, '{4'd9, 4'd9, 4'd9}
  };

  typedef enum logic {
    BE_IDLE,
    BE_RENDER
  } be_state_t;

  function automatic int atlas_addr_w(input int tile_size, input int tiles_per_row);
    int w;
    w = tile_size * tiles_per_row;
    return $clog2(w * w);
  endfunction

endpackage

// ----- rtl/tile_sprite_tinted_renderer.sv -----
// ----------------------------------------------------------------------------
// tile_sprite_tinted_renderer
// Tinted sprite-row renderer over an RGBA atlas held in on-chip RAM.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave
// through one (pop/empty). A load item writes one atlas texel; a render
// item reads TILE_SIZE texels, one atlas RAM read per cycle while the
// result queue has credit, so back-to-back rows stream one pixel per
// cycle. Each pixel passes the registered atlas read and then blend
// stages A, B, C and D before it reaches the result side. The input
// side decodes into a CMD_DEPTH-entry command queue and the blend pipeline
// drains into an OUT_DEPTH-entry result queue, so a stalled consumer only
// stops the atlas reads once that queue is committed full. Loads with an
// address outside the atlas and renders of a row outside the sprite are
// accepted and produce nothing. The atlas is not cleared at reset: each
// texel must be loaded before a row that covers it is rendered.
module tile_sprite_tinted_renderer import tstr_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEFAULT,
  parameter int ATLAS_TILES_PER_ROW = ATLAS_TILES_PER_ROW_DEFAULT,
  localparam int AW = atlas_addr_w(TILE_SIZE, ATLAS_TILES_PER_ROW),
  localparam int RW = $clog2(TILE_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          req_type,
  input  logic [15:0]   cell_code,
  input  logic [15:0]   goal_code,
  input  logic [1:0]    agent_orientation,
  input  logic [RW-1:0] pixel_row,
  input  logic [AW-1:0] texel_address,
  input  logic [7:0]    texel_red,
  input  logic [7:0]    texel_green,
  input  logic [7:0]    texel_blue,
  input  logic [7:0]    texel_alpha,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    pixel_red,
  output logic [7:0]    pixel_green,
  output logic [7:0]    pixel_blue,
  output logic [RW-1:0] pixel_column,
  output logic          last_pixel
);

  localparam int CMD_W = 1 + AW + 32 + 6;
  localparam int PIX_W = 24 + RW + 1;

  typedef struct packed {
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [RW-1:0] col;
    logic          last;
  } pix_t;

  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wdata;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             pix_push;
  logic [PIX_W-1:0] pix_wdata;
  logic [PIX_W-1:0] pix_rdata;
  logic             out_pop;
  logic             out_full;
  pix_t             pix;

  tstr_front #(
    .TILE_SIZE           (TILE_SIZE),
    .ATLAS_TILES_PER_ROW (ATLAS_TILES_PER_ROW)
  ) u_front (
    .push              (push),
    .req_type          (req_type),
    .cell_code         (cell_code),
    .goal_code         (goal_code),
    .agent_orientation (agent_orientation),
    .pixel_row         (pixel_row),
    .texel_address     (texel_address),
    .texel_red         (texel_red),
    .texel_green       (texel_green),
    .texel_blue        (texel_blue),
    .texel_alpha       (texel_alpha),
    .cmd_push          (cmd_push),
    .cmd_data          (cmd_wdata)
  );

  tstr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  tstr_back #(
    .TILE_SIZE           (TILE_SIZE),
    .ATLAS_TILES_PER_ROW (ATLAS_TILES_PER_ROW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .pix_push  (pix_push),
    .pix_data  (pix_wdata)
  );

  // never overflows: the back end holds a credit for every pixel in flight
  tstr_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (pix_push),
    .wdata (pix_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (pix_rdata),
    .empty (empty)
  );

  assign out_pop = pop && !empty && !(out_full && 1'b0);
  assign pix     = pix_t'(pix_rdata);

  assign pixel_red    = pix.red;
  assign pixel_green  = pix.green;
  assign pixel_blue   = pix.blue;
  assign pixel_column = pix.col;
  assign last_pixel   = pix.last;

endmodule

// ----- rtl/tstr_ram.sv -----
// ----------------------------------------------------------------------------
// tstr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tstr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4900,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tstr_fifo.sv -----
// ----------------------------------------------------------------------------
// tstr_fifo
// Small register FIFO with full/empty flags; head entry is shown directly.
// ----------------------------------------------------------------------------
module tstr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/tstr_front.sv -----
// ----------------------------------------------------------------------------
// tstr_front
// Input decode: sorts items into texel loads and row renders, maps the cell
// code to an atlas tile, forms the atlas address and drops items that have
// no effect.
// ----------------------------------------------------------------------------
module tstr_front import tstr_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEFAULT,
  parameter int ATLAS_TILES_PER_ROW = ATLAS_TILES_PER_ROW_DEFAULT,
  localparam int AW = atlas_addr_w(TILE_SIZE, ATLAS_TILES_PER_ROW),
  localparam int RW = $clog2(TILE_SIZE),
  localparam int CMD_W = 1 + AW + 32 + 6
) (
  input  logic             push,
  input  logic             req_type,
  input  logic [15:0]      cell_code,
  input  logic [15:0]      goal_code,
  input  logic [1:0]       agent_orientation,
  input  logic [RW-1:0]    pixel_row,
  input  logic [AW-1:0]    texel_address,
  input  logic [7:0]       texel_red,
  input  logic [7:0]       texel_green,
  input  logic [7:0]       texel_blue,
  input  logic [7:0]       texel_alpha,
  output logic             cmd_push,
  output logic [CMD_W-1:0] cmd_data
);

  localparam int ATLAS_WIDTH = TILE_SIZE * ATLAS_TILES_PER_ROW;
  localparam int ATLAS_DEPTH = ATLAS_WIDTH * ATLAS_WIDTH;

  typedef struct packed {
    logic          is_render;
    logic [AW-1:0] addr;
    logic [31:0]   texel;
    logic [2:0]    fg_idx;
    logic [2:0]    bg_idx;
  } cmd_t;

  logic [15:0]   tile_code;
  logic [1:0]    tile_row;
  logic [2:0]    tile_col;
  logic [AW-1:0] row_base;
  logic [AW-1:0] base;
  logic          keep;
  cmd_t          cmd;

  assign tile_code = cell_code & ~TINT_MASK;

  always_comb begin
    unique case (tile_code)
      TC_EMPTY: begin tile_row = 2'd0; tile_col = 3'd0; end
      TC_R1C0:  begin tile_row = 2'd1; tile_col = 3'd0; end
      TC_R1C1:  begin tile_row = 2'd1; tile_col = 3'd1; end
      TC_R1C2:  begin tile_row = 2'd1; tile_col = 3'd2; end
      TC_R1C3:  begin tile_row = 2'd1; tile_col = 3'd3; end
      TC_R1C4:  begin tile_row = 2'd1; tile_col = 3'd4; end
      TC_R2C0:  begin tile_row = 2'd2; tile_col = 3'd0; end
      TC_R2C1:  begin tile_row = 2'd2; tile_col = 3'd1; end
      TC_R2C2:  begin tile_row = 2'd2; tile_col = 3'd2; end
      TC_R2C3:  begin tile_row = 2'd2; tile_col = 3'd3; end
      TC_R2C4:  begin tile_row = 2'd2; tile_col = 3'd4; end
      TC_R3C0:  begin tile_row = 2'd3; tile_col = 3'd0; end
      TC_R3C1:  begin tile_row = 2'd3; tile_col = 3'd1; end
      TC_R3C2:  begin tile_row = 2'd3; tile_col = 3'd2; end
      default: begin
        // agent codes carry bit 1; facing picks one of four columns
        if (tile_code[1]) begin
          tile_row = 2'd0;
          tile_col = 3'd1 + 3'(agent_orientation);
        end else begin
          tile_row = 2'd3;
          tile_col = 3'd4;
        end
      end
    endcase
  end

  assign row_base = AW'(tile_row) * AW'(TILE_SIZE) + AW'(pixel_row);
  assign base     = row_base * AW'(ATLAS_WIDTH) + AW'(tile_col) * AW'(TILE_SIZE);

  always_comb begin
    if (req_type == REQ_RENDER) begin
      keep = {1'b0, pixel_row} < (RW + 1)'(TILE_SIZE);
    end else begin
      keep = {1'b0, texel_address} < (AW + 1)'(ATLAS_DEPTH);
    end
  end

  always_comb begin
    cmd.is_render = req_type == REQ_RENDER;
    cmd.addr      = cmd.is_render ? base : texel_address;
    cmd.texel     = {texel_alpha, texel_blue, texel_green, texel_red};
    cmd.fg_idx    = cell_code[TINT_LSB +: 3];
    cmd.bg_idx    = goal_code[TINT_LSB +: 3];
  end

  assign cmd_push = push && keep;
  assign cmd_data = cmd;

endmodule

// ----- rtl/tstr_back.sv -----
// ----------------------------------------------------------------------------
// tstr_back
// Execution side: writes texels into the atlas RAM, walks the columns of a
// sprite row one read per cycle and blends each texel in a four-stage
// pipeline. Issue is throttled by credits against the result queue.
// ----------------------------------------------------------------------------
module tstr_back import tstr_pkg::*; #(
  parameter int TILE_SIZE = TILE_SIZE_DEFAULT,
  parameter int ATLAS_TILES_PER_ROW = ATLAS_TILES_PER_ROW_DEFAULT,
  localparam int AW = atlas_addr_w(TILE_SIZE, ATLAS_TILES_PER_ROW),
  localparam int RW = $clog2(TILE_SIZE),
  localparam int CMD_W = 1 + AW + 32 + 6,
  localparam int PIX_W = 24 + RW + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  input  logic             out_pop,
  output logic             pix_push,
  output logic [PIX_W-1:0] pix_data
);

  localparam int ATLAS_WIDTH = TILE_SIZE * ATLAS_TILES_PER_ROW;
  localparam int ATLAS_DEPTH = ATLAS_WIDTH * ATLAS_WIDTH;
  localparam int RES_W       = $clog2(OUT_DEPTH + 1);
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic          is_render;
    logic [AW-1:0] addr;
    logic [31:0]   texel;
    logic [2:0]    fg_idx;
    logic [2:0]    bg_idx;
  } cmd_t;

  typedef struct packed {
    logic [RW-1:0] col;
    logic          last;
    logic [2:0]    fg_idx;
    logic [2:0]    bg_idx;
  } side_t;

  typedef struct packed {
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [RW-1:0] col;
    logic          last;
  } pix_t;

  cmd_t              head;
  be_state_t         state;
  be_state_t         state_next;
  logic [RW-1:0]     col;
  logic [AW-1:0]     rd_addr;
  logic [2:0]        cur_fg_idx;
  logic [2:0]        cur_bg_idx;
  logic [RES_W-1:0]  reserved;
  logic [RES_W-1:0]  reserved_next;
  logic              credit_ok;
  logic              issue;
  logic              ram_we;
  logic [AW-1:0]     raddr;
  logic [RW-1:0]     issue_col;
  side_t             issue_side;
  logic [31:0]       ram_rdata;

  // pipeline registers
  logic              a_valid, b_valid, c_valid, d_valid;
  side_t             a_side, b_side, c_side, d_side;
  logic [15:0]       b_as  [3];
  logic [11:0]       b_wb  [3];
  logic [NUM_W-1:0]  c_num [3];
  logic [NUM_W-1:0]  d_num [3];
  logic [Q_W-1:0]    d_q0  [3];

  // stage logic
  logic [15:0]       a_as   [3];
  logic [11:0]       a_wb   [3];
  logic [NUM_W-1:0]  b_num  [3];
  logic [PROD_W-1:0] c_prod [3];
  logic [Q_W-1:0]    c_q0   [3];
  logic [NUM_W:0]    d_rem  [3];
  logic [Q_W-1:0]    d_q    [3];
  logic [7:0]        d_pix  [3];
  pix_t              pix;

  assign head      = cmd_t'(cmd_data);
  assign credit_ok = reserved < RES_W'(OUT_DEPTH);

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      BE_IDLE: begin
        if (!cmd_empty && head.is_render && credit_ok) begin
          state_next = BE_RENDER;
        end
      end
      BE_RENDER: begin
        if (credit_ok && col == RW'(TILE_SIZE - 1)) begin
          state_next = BE_IDLE;
        end
      end
      default: state_next = BE_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    issue     = 1'b0;
    raddr     = rd_addr;
    issue_col = col;
    issue_side.fg_idx = cur_fg_idx;
    issue_side.bg_idx = cur_bg_idx;
    unique case (state)
      BE_IDLE: begin
        // column 0 goes out straight from the queue head
        raddr     = head.addr;
        issue_col = '0;
        issue_side.fg_idx = head.fg_idx;
        issue_side.bg_idx = head.bg_idx;
        if (!cmd_empty) begin
          if (head.is_render) begin
            issue   = credit_ok;
            cmd_pop = credit_ok;
          end else begin
            ram_we  = 1'b1;
            cmd_pop = 1'b1;
          end
        end
      end
      BE_RENDER: begin
        issue = credit_ok;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    issue_side.col  = issue_col;
    issue_side.last = issue_col == RW'(TILE_SIZE - 1);
  end

  // slots held for pixels in flight or waiting in the result queue
  always_comb begin
    unique case ({issue, out_pop})
      2'b10:   reserved_next = reserved + RES_W'(1);
      2'b01:   reserved_next = reserved - RES_W'(1);
      default: reserved_next = reserved;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BE_IDLE;
      reserved <= '0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      reserved <= reserved_next;
      a_valid  <= issue;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d_valid  <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      col     <= issue_col + RW'(1);
      rd_addr <= raddr + AW'(1);
    end
    if (state == BE_IDLE) begin
      cur_fg_idx <= head.fg_idx;
      cur_bg_idx <= head.bg_idx;
    end
  end

  tstr_ram #(
    .WIDTH (32),
    .DEPTH (ATLAS_DEPTH)
  ) u_atlas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.addr),
    .wdata (head.texel),
    .re    (issue),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // ---- blend pipeline ----
  // A: mask products   B: weighted sum   C: reciprocal multiply   D: fix-up
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      a_as[ch]   = 16'(ram_rdata[31:24]) * 16'(ram_rdata[8*ch +: 8]);
      a_wb[ch]   = 12'(8'd255 - ram_rdata[31:24]) * 12'(BG_TENTHS[a_side.bg_idx][ch]);
      // b*(255-a)*255 done as x*256 - x
      b_num[ch]  = NUM_W'(b_as[ch]) * NUM_W'(FG_TENTHS[b_side.fg_idx][ch])
                 + ((NUM_W'(b_wb[ch]) << 8) - NUM_W'(b_wb[ch]));
      c_prod[ch] = PROD_W'(c_num[ch]) * PROD_W'(RECIP);
      c_q0[ch]   = c_prod[ch][PROD_W-1:RECIP_SHIFT];
      // estimate is exact or one low
      d_rem[ch]  = (NUM_W + 1)'(d_num[ch])
                 - (NUM_W + 1)'(d_q0[ch]) * (NUM_W + 1)'(BLEND_DIV);
      d_q[ch]    = (d_rem[ch] >= (NUM_W + 1)'(BLEND_DIV)) ? d_q0[ch] + Q_W'(1) : d_q0[ch];
      d_pix[ch]  = (d_q[ch] > Q_W'(255)) ? 8'hFF : d_q[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    a_side <= issue_side;
    b_side <= a_side;
    c_side <= b_side;
    d_side <= c_side;
    for (int ch = 0; ch < 3; ch++) begin
      b_as[ch]  <= a_as[ch];
      b_wb[ch]  <= a_wb[ch];
      c_num[ch] <= b_num[ch];
      d_num[ch] <= c_num[ch];
      d_q0[ch]  <= c_q0[ch];
    end
  end

  always_comb begin
    pix.red   = d_pix[0];
    pix.green = d_pix[1];
    pix.blue  = d_pix[2];
    pix.col   = d_side.col;
    pix.last  = d_side.last;
  end

  assign pix_push = d_valid;
  assign pix_data = pix;

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tinted sprite-row renderer.
// ----------------------------------------------------------------------------
// Texel loads and row renders go in through the push/full port. Each accepted
// item in range updates a private atlas image or becomes the expected 14 pixels
// of the row. Popped pixels are compared field by field against the oldest
// expected pixel. A directed table covers the blend extremes, the tint
// corners and the ignored items. Random scenes follow: a sprite row is loaded
// with random texels, then rendered under random tints, mixed with stray
// loads and out-of-range items. Sender and receiver stall at random in three
// phases: receiver-heavy, sender-heavy, then no stalls.
// ----------------------------------------------------------------------------
module tb_top import tstr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE         = 14;
  localparam int ATLAS_W      = 70;
  localparam int ATLAS_N      = ATLAS_W * ATLAS_W;
  localparam int AGENT_BIT    = 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_PRINTS   = 100;

  localparam logic [15:0] UNKNOWN_CODE = 16'h0004;

  // tints in tenths, per index and channel
  localparam int TINT_FG [8][3] = '{
    '{4, 4, 4}, '{8, 2, 2}, '{2, 8, 2}, '{8, 8, 2},
    '{2, 2, 8}, '{8, 2, 8}, '{2, 8, 8}, '{10, 10, 10}
  };
  localparam int TINT_BG [8][3] = '{
    '{6, 6, 6}, '{9, 6, 6}, '{6, 9, 6}, '{9, 9, 6},
    '{5, 5, 9}, '{9, 6, 9}, '{6, 9, 9}, '{9, 9, 9}
  };

  localparam logic [15:0] TILE_CODES [14] = '{
    TC_EMPTY, TC_R1C0, TC_R1C1, TC_R1C2, TC_R1C3, TC_R1C4, TC_R2C0,
    TC_R2C1, TC_R2C2, TC_R2C3, TC_R2C4, TC_R3C0, TC_R3C1, TC_R3C2
  };

  typedef struct {
    logic        kind;
    logic [15:0] ccode;
    logic [15:0] goal;
    logic [1:0]  orient;
    logic [3:0]  row;
    logic [12:0] addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } sprite_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] col;
    logic       last;
  } pixel_t;

  typedef struct {
    sprite_req_t req;
    bit          fill;   // load every texel of the req's sprite row
    bit          typed;  // expected color written in the table
    logic [23:0] rgb;
  } dir_row_t;

  logic        clk;
  logic        rst               = 1'b1;
  logic        push              = 1'b0;
  logic        full;
  logic        req_type          = REQ_LOAD;
  logic [15:0] cell_code         = '0;
  logic [15:0] goal_code         = '0;
  logic [1:0]  agent_orientation = '0;
  logic [3:0]  pixel_row         = '0;
  logic [12:0] texel_address     = '0;
  logic [7:0]  texel_red         = '0;
  logic [7:0]  texel_green       = '0;
  logic [7:0]  texel_blue        = '0;
  logic [7:0]  texel_alpha       = '0;
  logic        empty;
  logic        pop               = 1'b0;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [3:0]  pixel_column;
  logic        last_pixel;

  logic [31:0] atlas_img [ATLAS_N];
  bit          written [ATLAS_N];
  pixel_t      pixel_q [$];
  dir_row_t    dir_tab [$];
  int          mismatches = 0;
  int          live_items = 0;
  int          snd_idle   = 6;
  int          rcv_idle   = 78;
  int          cycle_cnt  = 0;

  tile_sprite_tinted_renderer DUT (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .req_type          (req_type),
    .cell_code         (cell_code),
    .goal_code         (goal_code),
    .agent_orientation (agent_orientation),
    .pixel_row         (pixel_row),
    .texel_address     (texel_address),
    .texel_red         (texel_red),
    .texel_green       (texel_green),
    .texel_blue        (texel_blue),
    .texel_alpha       (texel_alpha),
    .empty             (empty),
    .pop               (pop),
    .pixel_red         (pixel_red),
    .pixel_green       (pixel_green),
    .pixel_blue        (pixel_blue),
    .pixel_column      (pixel_column),
    .last_pixel        (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // first atlas texel of the sprite row that a render item reads
  function automatic int row_base(logic [15:0] ccode, logic [1:0] orient, logic [3:0] row);
    logic [15:0] code;
    int trow;
    int tcol;
    code = ccode & ~TINT_MASK;
    case (code)
      TC_EMPTY: begin trow = 0; tcol = 0; end
      TC_R1C0:  begin trow = 1; tcol = 0; end
      TC_R1C1:  begin trow = 1; tcol = 1; end
      TC_R1C2:  begin trow = 1; tcol = 2; end
      TC_R1C3:  begin trow = 1; tcol = 3; end
      TC_R1C4:  begin trow = 1; tcol = 4; end
      TC_R2C0:  begin trow = 2; tcol = 0; end
      TC_R2C1:  begin trow = 2; tcol = 1; end
      TC_R2C2:  begin trow = 2; tcol = 2; end
      TC_R2C3:  begin trow = 2; tcol = 3; end
      TC_R2C4:  begin trow = 2; tcol = 4; end
      TC_R3C0:  begin trow = 3; tcol = 0; end
      TC_R3C1:  begin trow = 3; tcol = 1; end
      TC_R3C2:  begin trow = 3; tcol = 2; end
      default: begin
        if (code[AGENT_BIT]) begin
          trow = 0;
          tcol = 1 + int'(orient);
        end else begin
          trow = 3;
          tcol = 4;
        end
      end
    endcase
    return (trow * TILE + int'(row)) * ATLAS_W + tcol * TILE;
  endfunction

  // one channel: floor((b*(255-a)*255 + a*s*f) / 2550), tints in tenths
  function automatic logic [7:0] mix_channel(int s, int a, int f, int b);
    int v;
    v = (b * (255 - a) * 255 + a * s * f) / 2550;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic logic [15:0] tint(logic [15:0] code, int idx);
    return (code & ~TINT_MASK) | (16'(idx) << TINT_LSB);
  endfunction

  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(3))
      0: t[31:24] = 8'd0;
      1: t[31:24] = 8'd255;
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] gen_cell();
    logic [15:0] code;
    bit listed;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: code = TILE_CODES[$urandom_range(13)];
      6, 7: begin
        code = 16'($urandom);
        code[AGENT_BIT] = 1'b1;
      end
      8: begin
        do begin
          code = 16'($urandom);
          code[AGENT_BIT] = 1'b0;
          listed = 0;
          for (int i = 0; i < 14; i++)
            if ((code & ~TINT_MASK) == TILE_CODES[i]) listed = 1;
        end while (listed);
      end
      default: return 16'($urandom);
    endcase
    return tint(code, $urandom_range(7));
  endfunction

  function automatic sprite_req_t mk_req(logic kind, logic [15:0] ccode, logic [15:0] goal,
                                         logic [1:0] orient, logic [3:0] row,
                                         logic [12:0] addr, logic [31:0] rgba);
    sprite_req_t q;
    q.kind   = kind;
    q.ccode  = ccode;
    q.goal   = goal;
    q.orient = orient;
    q.row    = row;
    q.addr   = addr;
    q.red    = rgba[7:0];
    q.green  = rgba[15:8];
    q.blue   = rgba[23:16];
    q.alpha  = rgba[31:24];
    return q;
  endfunction

  function automatic dir_row_t mk_dir(bit fill, bit typed, logic [23:0] rgb, sprite_req_t q);
    dir_row_t d;
    d.req   = q;
    d.fill  = fill;
    d.typed = typed;
    d.rgb   = rgb;
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t ERROR: %s", $time, msg);
  endtask

  // drive one item, wait for it to be taken, then work out what it causes
  task automatic issue_req(sprite_req_t q, bit typed, logic [23:0] rgb);
    int base;
    int fi;
    int bi;
    logic [31:0] t;
    pixel_t p;
    if ($urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    push              <= 1'b1;
    req_type          <= q.kind;
    cell_code         <= q.ccode;
    goal_code         <= q.goal;
    agent_orientation <= q.orient;
    pixel_row         <= q.row;
    texel_address     <= q.addr;
    texel_red         <= q.red;
    texel_green       <= q.green;
    texel_blue        <= q.blue;
    texel_alpha       <= q.alpha;
    @(posedge clk);
    while (full) @(posedge clk);
    if (q.kind == REQ_LOAD) begin
      if (q.addr < ATLAS_N) begin
        atlas_img[q.addr] = {q.alpha, q.blue, q.green, q.red};
        live_items++;
      end
    end else if (q.row < TILE) begin
      live_items++;
      base = row_base(q.ccode, q.orient, q.row);
      fi = int'(q.ccode[TINT_LSB +: 3]);
      bi = int'(q.goal[TINT_LSB +: 3]);
      for (int c = 0; c < TILE; c++) begin
        if (typed) begin
          {p.red, p.green, p.blue} = rgb;
        end else begin
          t = atlas_img[base + c];
          p.red   = mix_channel(int'(t[7:0]), int'(t[31:24]),
                                TINT_FG[fi][0], TINT_BG[bi][0]);
          p.green = mix_channel(int'(t[15:8]), int'(t[31:24]),
                                TINT_FG[fi][1], TINT_BG[bi][1]);
          p.blue  = mix_channel(int'(t[23:16]), int'(t[31:24]),
                                TINT_FG[fi][2], TINT_BG[bi][2]);
        end
        p.col  = 4'(c);
        p.last = (c == TILE - 1);
        pixel_q.push_back(p);
      end
    end
  endtask

  task automatic load_texel(int addr, logic [31:0] rgba);
    if (addr < ATLAS_N) written[addr] = 1'b1;
    issue_req(mk_req(REQ_LOAD, 16'($urandom), 16'($urandom), 2'($urandom), 4'($urandom),
                     13'(addr), rgba), 1'b0, '0);
  endtask

  task automatic render(logic [15:0] ccode, logic [15:0] goal, logic [1:0] orient,
                        logic [3:0] row);
    issue_req(mk_req(REQ_RENDER, ccode, goal, orient, row, 13'($urandom), $urandom),
              1'b0, '0);
  endtask

  // mostly: fill a sprite row, then render it under a few tints
  task automatic run_random(int n_items);
    int target;
    int base;
    logic [15:0] ccode;
    logic [1:0] orient;
    logic [3:0] row;
    int pick;
    target = live_items + n_items;
    while (live_items < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        load_texel($urandom_range(ATLAS_N - 1), rand_texel());
      end else if (pick < 15) begin
        load_texel($urandom_range(8191, ATLAS_N), rand_texel());
      end else if (pick < 20) begin
        render(16'($urandom), 16'($urandom), 2'($urandom), 4'($urandom_range(15, TILE)));
      end else begin
        ccode  = gen_cell();
        orient = 2'($urandom);
        case ($urandom_range(3))
          0: row = 4'd0;
          1: row = 4'(TILE - 1);
          default: row = 4'($urandom_range(TILE - 1));
        endcase
        base = row_base(ccode, orient, row);
        for (int c = 0; c < TILE; c++)
          if (!written[base + c] || $urandom_range(7) == 0)
            load_texel(base + c, rand_texel());
        repeat ($urandom_range(1, 3)) begin
          render(ccode, 16'($urandom), orient, row);
          ccode = tint(ccode, $urandom_range(7));
        end
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t e;
    if (pixel_q.size() == 0) begin
      report_mismatch($sformatf("pixel col %0d rgb %0d/%0d/%0d with none expected",
                                pixel_column, pixel_red, pixel_green, pixel_blue));
    end else begin
      e = pixel_q.pop_front();
      if (pixel_red !== e.red || pixel_green !== e.green || pixel_blue !== e.blue ||
          pixel_column !== e.col || last_pixel !== e.last)
        report_mismatch($sformatf({"pixel got rgb %0d/%0d/%0d col %0d last %0d, ",
                                   "exp %0d/%0d/%0d col %0d last %0d"},
                                  pixel_red, pixel_green, pixel_blue, pixel_column, last_pixel,
                                  e.red, e.green, e.blue, e.col, e.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_pixel();
    pop <= ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    int base;
    // solid white row under tints, then a clear row showing the background alone
    dir_tab.push_back(mk_dir(1, 0, '0,
      mk_req(REQ_LOAD, TC_EMPTY, 16'h0000, 2'd0, 4'd0, '0, 32'hFFFF_FFFF)));
    dir_tab.push_back(mk_dir(0, 1, 24'hFFFFFF,
      mk_req(REQ_RENDER, tint(TC_EMPTY, 7), 16'hFFFF, 2'd0, 4'd0, '0, '0)));
    dir_tab.push_back(mk_dir(0, 1, 24'h666666,
      mk_req(REQ_RENDER, tint(TC_EMPTY, 0), 16'h0000, 2'd1, 4'd0, '0, '0)));
    dir_tab.push_back(mk_dir(0, 1, 24'hCC3333,
      mk_req(REQ_RENDER, tint(TC_EMPTY, 1), 16'hFFFF, 2'd2, 4'd0, '0, '0)));
    dir_tab.push_back(mk_dir(1, 0, '0,
      mk_req(REQ_LOAD, UNKNOWN_CODE, 16'h0000, 2'd0, 4'(TILE - 1), '0, 32'h0000_0000)));
    dir_tab.push_back(mk_dir(0, 1, 24'hE5E5E5,
      mk_req(REQ_RENDER, tint(UNKNOWN_CODE, 7), tint(16'h0000, 7), 2'd0, 4'(TILE - 1),
             '0, '0)));
    dir_tab.push_back(mk_dir(0, 1, 24'h7F7FE5,
      mk_req(REQ_RENDER, UNKNOWN_CODE, tint(16'h0000, 4), 2'd0, 4'(TILE - 1), '0, '0)));
    dir_tab.push_back(mk_dir(0, 1, 24'h999999,
      mk_req(REQ_RENDER, 16'hFFFD, 16'h0000, 2'd3, 4'(TILE - 1), '0, '0)));
    // ignored: loads past the atlas, rows past the sprite
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_LOAD, 16'hFFFF, 16'hFFFF, 2'd3, 4'd15, 13'h1FFF, 32'h1234_5678)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_LOAD, 16'h0000, 16'h0000, 2'd0, 4'd0, 13'(ATLAS_N), 32'hFFFF_FFFF)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_RENDER, TC_EMPTY, 16'h0000, 2'd0, 4'(TILE), '0, '0)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_RENDER, 16'hFFFF, 16'hFFFF, 2'd3, 4'd15, 13'h1FFF, 32'hFFFF_FFFF)));
    // partial blends within the white row
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_LOAD, 16'h0000, 16'h0000, 2'd0, 4'd0, 13'd5, 32'h8000_64C8)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_LOAD, 16'h0000, 16'h0000, 2'd0, 4'd0, 13'(TILE - 1), 32'h00FF_0000)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_LOAD, 16'h0000, 16'h0000, 2'd0, 4'd0, 13'd0, 32'h7F01_0203)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_RENDER, tint(TC_EMPTY, 3), tint(16'h0000, 5), 2'd0, 4'd0, '0, '0)));
    dir_tab.push_back(mk_dir(0, 0, '0,
      mk_req(REQ_RENDER, tint(TC_EMPTY, 7), 16'hFFFF, 2'd0, 4'd0, '0, '0)));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].fill) begin
        base = row_base(dir_tab[i].req.ccode, dir_tab[i].req.orient, dir_tab[i].req.row);
        for (int c = 0; c < TILE; c++)
          load_texel(base + c, {dir_tab[i].req.alpha, dir_tab[i].req.blue,
                                dir_tab[i].req.green, dir_tab[i].req.red});
      end else begin
        if (dir_tab[i].req.kind == REQ_LOAD && dir_tab[i].req.addr < ATLAS_N)
          written[dir_tab[i].req.addr] = 1'b1;
        issue_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rgb);
      end
    end

    run_random(RANDOM_ITEMS / 3);
    snd_idle = 78;
    rcv_idle = 6;
    run_random(RANDOM_ITEMS / 3);
    snd_idle = 0;
    rcv_idle = 0;
    run_random(RANDOM_ITEMS / 3);
    push <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tstr_pkg.sv
rtl/tstr_ram.sv
rtl/tstr_fifo.sv
rtl/tstr_front.sv
rtl/tstr_back.sv
rtl/tile_sprite_tinted_renderer.sv
verif/tb_top.sv
